// File: hdl/mfh_pkg.sv
// ----------------------------------------------------------------------------
// mfh_pkg
// Shared constants, types and the finalization mix of the FNV-1a stream hash.
// ----------------------------------------------------------------------------
package mfh_pkg;

   localparam int HASH_W = 32;
   localparam int BYTE_W = 8;

   localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
   localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              has_byte;
      logic              first;
      logic              last;
      logic [HASH_W-1:0] seed;
   } item_type;

   typedef struct packed {
      logic              valid;
      logic [HASH_W-1:0] hash;
   } folded_type;

   function automatic logic [HASH_W-1:0] final_mix(input logic [HASH_W-1:0] h);
      logic [HASH_W-1:0] x;
      x = h;
      x = x + (x << 13);
      x = x ^ (x >> 7);
      x = x + (x << 3);
      x = x ^ (x >> 17);
      x = x + (x << 5);
      return x;
   endfunction

endpackage

// File: hdl/modified_fnv_hash_stream.sv
// ----------------------------------------------------------------------------
// modified_fnv_hash_stream
// Streaming 32-bit FNV-1a hash, one byte per transfer, with a final
// shift-add avalanche; one result per message on its last item.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   data_byte, has_byte, first, last, seed
//   rsp      out        rsp_valid/rsp_stall   hash_value
//
// One item per cycle while req_stall is low; the running-hash multiply by the
// FNV prime sets the loop that limits the clock. A result becomes valid once its
// last item has passed the input register, the fold register, then the result register.
// Synchronous active-high reset clears all valid flags and the running hash.
// A stalled result holds; one more folded hash waits behind it, and req_stall
// rises only once the next last item sits in the input register. Items
// without last keep flowing meanwhile.
// ----------------------------------------------------------------------------
module modified_fnv_hash_stream (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [mfh_pkg::BYTE_W-1:0]  req_data_byte,
   input  logic                        req_has_byte,
   input  logic                        req_first,
   input  logic                        req_last,
   input  logic [mfh_pkg::HASH_W-1:0]  req_seed,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [mfh_pkg::HASH_W-1:0]  rsp_hash_value
);
   import mfh_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   item_type   in_item_ff;
   logic       item_move;
   logic       fold_move;
   logic       fold_free;
   logic       rsp_free;
   logic       req_take;
   folded_type folded;

   assign fold_move = folded.valid && rsp_free;
   assign fold_free = !folded.valid || rsp_free;
   assign item_move = in_valid_ff && (!in_item_ff.last || fold_free);
   assign req_stall = in_valid_ff && !item_move;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      priority if (req_take) begin
         in_valid_in = 1'b1;
      end else if (item_move) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_item_ff.data_byte <= req_data_byte;
         in_item_ff.has_byte  <= req_has_byte;
         in_item_ff.first     <= req_first;
         in_item_ff.last      <= req_last;
         in_item_ff.seed      <= req_seed;
      end
   end

   mfh_fold u_fold (
      .clock     (clock),
      .reset     (reset),
      .item_move (item_move),
      .item      (in_item_ff),
      .fold_move (fold_move),
      .folded    (folded)
   );

   mfh_final u_final (
      .clock          (clock),
      .reset          (reset),
      .fold_move      (fold_move),
      .fold_hash      (folded.hash),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_hash_value (rsp_hash_value),
      .rsp_free       (rsp_free)
   );

   a_fold_holds: assert property (@(posedge clock) disable iff (reset)
      folded.valid && !rsp_free |=> folded.valid)
      else $error("folded hash dropped while result register was busy");

   a_last_blocked: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_item_ff.last && !fold_free |-> req_stall)
      else $error("input taken while last item could not advance");

   a_fold_to_rsp: assert property (@(posedge clock) disable iff (reset)
      fold_move |=> rsp_valid)
      else $error("folded hash did not reach the result register");

   a_reset_clear: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule

// File: hdl/mfh_fold.sv
// ----------------------------------------------------------------------------
// mfh_fold
// Running FNV-1a state: loads basis XOR seed on first, folds one byte per
// transfer, and registers the folded hash of a message's last item.
// ----------------------------------------------------------------------------
module mfh_fold (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_move,
   input  mfh_pkg::item_type   item,
   input  logic                fold_move,
   output mfh_pkg::folded_type folded
);
   import mfh_pkg::*;

   logic [HASH_W-1:0] running_hash_ff;
   logic [HASH_W-1:0] running_hash_in;
   logic [HASH_W-1:0] base_hash;
   logic              fold_valid_ff;
   logic              fold_valid_in;
   logic [HASH_W-1:0] fold_hash_ff;
   logic [HASH_W-1:0] fold_hash_in;

   always_comb begin
      base_hash = item.first ? (FNV_BASIS ^ item.seed) : running_hash_ff;
      if (item.has_byte) begin
         running_hash_in = (base_hash ^ {{(HASH_W-BYTE_W){1'b0}}, item.data_byte}) * FNV_PRIME;
      end else begin
         running_hash_in = base_hash;
      end
   end

   always_comb begin
      fold_valid_in = fold_valid_ff;
      fold_hash_in  = fold_hash_ff;
      priority if (item_move && item.last) begin
         fold_valid_in = 1'b1;
         fold_hash_in  = running_hash_in;
      end else if (fold_move) begin
         fold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_hash_ff <= '0;
         fold_valid_ff   <= 1'b0;
      end else begin
         if (item_move) begin
            running_hash_ff <= running_hash_in;
         end
         fold_valid_ff <= fold_valid_in;
      end
      fold_hash_ff <= fold_hash_in;
   end

   assign folded.valid = fold_valid_ff;
   assign folded.hash  = fold_hash_ff;

endmodule

// File: hdl/mfh_final.sv
// ----------------------------------------------------------------------------
// mfh_final
// Applies the shift-add avalanche to a folded hash and holds the result
// register of the response channel.
// ----------------------------------------------------------------------------
module mfh_final (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fold_move,
   input  logic [mfh_pkg::HASH_W-1:0]  fold_hash,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic [mfh_pkg::HASH_W-1:0]  rsp_hash_value,
   output logic                        rsp_free
);
   import mfh_pkg::*;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [HASH_W-1:0] rsp_hash_ff;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      priority if (fold_move) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fold_move) begin
         rsp_hash_ff <= final_mix(fold_hash);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

endmodule
